// File: hw/rtl/p24fc_pkg.sv
// Package for the packed24 float converter: payload structs, status codes.
// No dependencies.
`timescale 1ns / 1ps
package p24fc_pkg;
  localparam logic [7:0] PK_BIAS = 8'd80;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [23:0] packed_word;
    logic [31:0] float_bits;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] float_result;
    logic [23:0] packed_result;
    logic [1:0]  status;
  } out_beat_t;
endpackage

// File: hw/rtl/packed24_float_converter.sv
// Packed24 <-> IEEE single converter, three-stage pipeline.
// Throughput one beat per cycle while the output is not stalled.
// Stage 1 negates/classifies, stage 2 counts leading zeros, stage 3 assembles.
// All stages advance together when the output stage is free or being drained.
// Synchronous active-high rst clears the stage valid bits; payload is not reset.
`timescale 1ns / 1ps
module packed24_float_converter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  p24fc_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output p24fc_pkg::out_beat_t out_data
);
  import p24fc_pkg::*;

  logic advance;
  logic v1, v2, v3;

  // stage 1 registers
  logic        op1, neg1;
  logic [7:0]  e1;
  logic [15:0] m1;
  logic [23:0] pk1;
  logic [1:0]  st1;

  // stage 2 registers
  logic        op2, neg2;
  logic [7:0]  e2;
  logic [15:0] m2;
  logic [3:0]  p2;
  logic [23:0] pk2;
  logic [1:0]  st2;

  out_beat_t   res3;

  assign advance  = !v3 || out_ready;
  assign in_ready = advance;

  // stage 1: decode magnitude, encode fully (encode is shallow)
  logic [23:0] dmag;
  logic        fneg;
  logic [7:0]  bexp;
  logic [22:0] frac;
  logic [8:0]  ee;
  logic [23:0] emag, epk;
  logic [1:0]  est;
  always_comb begin
    dmag = in_data.packed_word[23] ? (24'd0 - in_data.packed_word) : in_data.packed_word;
    fneg = in_data.float_bits[31];
    bexp = in_data.float_bits[30:23];
    frac = in_data.float_bits[22:0];
    ee   = {1'b0, bexp} - 9'd62;
    est  = ST_OK;
    emag = 24'd0;
    if (bexp == 8'hFF) begin
      est = ST_INVALID;
    end else if (bexp == 8'd0) begin
      if (frac != 23'd0) est = ST_UNDERFLOW;
    end else if (ee[8]) begin
      est = ST_UNDERFLOW;
    end else if (ee[7]) begin
      est  = ST_OVERFLOW;
      emag = 24'h7FFFFF;
    end else begin
      emag = {ee[7:0], 1'b1, frac[22:8]};
    end
    epk = fneg ? (24'd0 - emag) : emag;
  end

  // stage 2: leading-one position of mantissa
  logic [3:0] pos;
  always_comb begin
    pos = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (m1[i]) pos = 4'(i);
    end
  end

  // stage 3: assemble single
  logic [7:0]  fexp;
  logic [22:0] ffrac;
  logic [38:0] sh;
  always_comb begin
    fexp  = {4'd0, p2} + e2 + 8'd127 - PK_BIAS;
    sh    = {23'd0, m2} << (5'd23 - {1'b0, p2});
    ffrac = sh[22:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op1  <= in_data.operation;
      neg1 <= in_data.packed_word[23];
      e1   <= dmag[23:16];
      m1   <= dmag[15:0];
      pk1  <= epk;
      st1  <= est;

      op2  <= op1;
      neg2 <= neg1;
      e2   <= e1;
      m2   <= m1;
      p2   <= pos;
      pk2  <= pk1;
      st2  <= st1;

      if (op2 == OP_ENCODE) begin
        res3.float_result  <= 32'd0;
        res3.packed_result <= pk2;
        res3.status        <= st2;
      end else begin
        res3.packed_result <= 24'd0;
        res3.status        <= ST_OK;
        if (m2 == 16'd0) res3.float_result <= {neg2, 31'd0};
        else res3.float_result <= {neg2, fexp, ffrac};
      end
    end
  end

  assign out_valid = v3;
  assign out_data  = res3;
endmodule

// File: hw/rtl/p24fc_checker.sv
// Port-level checker for packed24_float_converter, bound to the top level.
// Depends on p24fc_pkg.
`timescale 1ns / 1ps
module p24fc_sva (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input p24fc_pkg::in_beat_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input p24fc_pkg::out_beat_t out_data
);
  import p24fc_pkg::*;

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");

  // ready whenever output is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("in_ready low with empty output");

  // an accepted beat reaches the output while the pipeline keeps advancing
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 in_ready ##1 in_ready |=> out_valid) else $error("latency");

  // at most one of the two results is nonzero per beat
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.float_result == 32'd0) || (out_data.packed_result == 24'd0))
    else $error("both results set");
endmodule

bind packed24_float_converter p24fc_sva u_p24fc_sva (.*);
